@@ hw/rtl/pisd_pkg.sv @@
// Shared types, codes and small tables for the paletted index store decoder.
// No dependencies; pisd_dp, pisd_ctrl and the top level import this package.
package pisd_pkg;

  localparam logic [1:0] OP_HDR = 2'd0;
  localparam logic [1:0] OP_VAL = 2'd1;
  localparam logic [1:0] OP_GET = 2'd2;
  localparam logic [1:0] OP_SET = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_WIDTH = 3'd1;
  localparam logic [2:0] ST_SIZE  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_SEQ   = 3'd4;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 16;
  localparam logic [6:0] MAX_ENTRY_W = 7'd16;

  // palette write address/data select
  localparam logic [1:0] PW_ZERO  = 2'd0;
  localparam logic [1:0] PW_PCNT  = 2'd1;
  localparam logic [1:0] PW_COUNT = 2'd2;

  // index store write address/data select
  localparam logic [1:0] IW_ZERO = 2'd0;
  localparam logic [1:0] IW_SLOT = 2'd1;
  localparam logic [1:0] IW_IDX  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] stream_value;
    logic [11:0] position;
    logic [31:0] new_id;
  } pisd_in_t;

  typedef struct packed {
    logic [31:0] id_out;
    logic [2:0]  status;
    logic        load_done;
  } pisd_out_t;

  typedef struct packed {
    logic       capture;
    logic       pos_sub;
    logic       width_ld;
    logic       uni_set;
    logic       uni_clr;
    logic       cnt_one;
    logic       cnt_ld;
    logic       cnt_inc;
    logic       pcnt_clr;
    logic       pcnt_inc;
    logic       ent_clr;
    logic       ent_inc;
    logic       shr_ld;
    logic       shr_shift;
    logic       idx_zero;
    logic       idx_ld_ram;
    logic       idx_ld_pcnt;
    logic       idx_ld_count;
    logic       pal_we;
    logic [1:0] pal_wsel;
    logic       idx_we;
    logic [1:0] idx_wsel;
    logic       idx_rsel;
    logic       pal_rsel;
    logic       fin;
    logic [2:0] fin_status;
    logic       fin_done;
    logic       fin_get;
  } pisd_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pos_ge;
    logic       hdr_zero;
    logic       hdr_big;
    logic       size_bad;
    logic       srch_end;
    logic       match;
    logic       full;
    logic       idx_is_zero;
    logic       uniform;
    logic       ids_last;
    logic       ent_last;
    logic       slot_last;
    logic       stale;
  } pisd_stat_t;

  // indices held in one packed word for a given entry width
  function automatic logic [5:0] slots_of(input logic [4:0] b);
    logic [5:0] n;
    case (b)
      5'd1:    n = 6'd32;
      5'd2:    n = 6'd16;
      5'd3:    n = 6'd10;
      5'd4:    n = 6'd8;
      5'd5:    n = 6'd6;
      5'd6:    n = 6'd5;
      5'd7:    n = 6'd4;
      5'd8:    n = 6'd4;
      5'd9:    n = 6'd3;
      5'd10:   n = 6'd3;
      default: n = 6'd2;
    endcase
    return n;
  endfunction

  function automatic logic [15:0] mask_of(input logic [4:0] b);
    logic [16:0] m;
    m = (17'd1 << b) - 17'd1;
    return m[15:0];
  endfunction

endpackage

@@ hw/rtl/pisd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pisd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/pisd_dp.sv @@
// Datapath: captured item, palette and index RAMs, counters, unpack shifter,
// result register. Depends on pisd_pkg and pisd_ram.
module pisd_dp
  import pisd_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT   = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pisd_in_t   in_item,
  input  pisd_cmd_t  cmd,
  output pisd_stat_t stat,
  output logic       out_strobe,
  output pisd_out_t  out_item
);

  localparam int unsigned EAW = $clog2(ENTRY_COUNT);
  localparam int unsigned PAW = $clog2(PALETTE_DEPTH);
  localparam int unsigned CW  = $clog2(PALETTE_DEPTH + 1);

  logic [1:0]        op_r;
  logic [31:0]       val_r;
  logic [11:0]       pos_r;
  logic [31:0]       nid_r;
  logic [CW-1:0]     count_r;
  logic              uniform_r;
  logic [4:0]        width_r;
  logic [CW-1:0]     pcnt_r;
  logic [EAW-1:0]    ent_r;
  logic [31:0]       shr_r;
  logic [5:0]        slot_r;
  logic [PAW-1:0]    idx_r;
  logic [PALETTE_DEPTH-1:0] pal_vld_r;
  logic              vld_q_r;
  logic              zero_q_r;
  logic              out_vld_r;
  pisd_out_t         out_r;

  logic              pal_we;
  logic [PAW-1:0]    pal_waddr;
  logic [31:0]       pal_wdata;
  logic [PAW-1:0]    pal_raddr;
  logic [31:0]       pal_rdata;
  logic [31:0]       pal_eff;
  logic [EAW-1:0]    idx_waddr;
  logic [15:0]       idx_wdata;
  logic [EAW-1:0]    idx_raddr;
  logic [15:0]       idx_rdata;
  logic [6:0]        hdr_b;

  assign hdr_b = val_r[7:1];

  always_comb begin
    case (cmd.pal_wsel)
      PW_ZERO:  pal_waddr = '0;
      PW_PCNT:  pal_waddr = pcnt_r[PAW-1:0];
      default:  pal_waddr = count_r[PAW-1:0];
    endcase
    pal_wdata = (cmd.pal_wsel == PW_COUNT) ? nid_r : val_r;
    pal_we    = cmd.pal_we;
    pal_raddr = cmd.pal_rsel ? idx_r : pcnt_r[PAW-1:0];
    case (cmd.idx_wsel)
      IW_ZERO: begin
        idx_waddr = ent_r;
        idx_wdata = '0;
      end
      IW_SLOT: begin
        idx_waddr = ent_r;
        idx_wdata = shr_r[15:0] & mask_of(width_r);
      end
      default: begin
        idx_waddr = pos_r[EAW-1:0];
        idx_wdata = 16'(idx_r);
      end
    endcase
    idx_raddr = cmd.idx_rsel ? ent_r : pos_r[EAW-1:0];
  end

  // never-written palette entries read as their reset value
  assign pal_eff = vld_q_r ? pal_rdata : 32'(zero_q_r);

  pisd_ram #(.WIDTH(WORD_W), .DEPTH(PALETTE_DEPTH)) u_pal (
    .clk(clk), .we(pal_we), .waddr(pal_waddr), .wdata(pal_wdata),
    .raddr(pal_raddr), .rdata(pal_rdata)
  );

  pisd_ram #(.WIDTH(INDEX_W), .DEPTH(ENTRY_COUNT)) u_idx (
    .clk(clk), .we(cmd.idx_we), .waddr(idx_waddr), .wdata(idx_wdata),
    .raddr(idx_raddr), .rdata(idx_rdata)
  );

  always_comb begin
    stat.opcode      = op_r;
    stat.pos_ge      = {1'b0, pos_r} >= 13'(ENTRY_COUNT);
    stat.hdr_zero    = (hdr_b == 7'd0);
    stat.hdr_big     = (hdr_b > MAX_ENTRY_W);
    stat.size_bad    = (val_r == 32'd0) || (val_r > 32'(PALETTE_DEPTH));
    stat.srch_end    = (pcnt_r >= count_r);
    stat.match       = (pal_eff == nid_r);
    stat.full        = (count_r >= CW'(PALETTE_DEPTH));
    stat.idx_is_zero = (idx_r == '0);
    stat.uniform     = uniform_r;
    stat.ids_last    = ({1'b0, pcnt_r} + (CW+1)'(1)) >= {1'b0, count_r};
    stat.ent_last    = (ent_r == EAW'(ENTRY_COUNT - 1));
    stat.slot_last   = ((slot_r + 6'd1) == slots_of(width_r));
    stat.stale       = (idx_rdata >= 16'(count_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_item.opcode;
      val_r <= in_item.stream_value;
      pos_r <= in_item.position;
      nid_r <= in_item.new_id;
    end else if (cmd.pos_sub) begin
      pos_r <= pos_r - 12'(ENTRY_COUNT);
    end
    if (cmd.pcnt_clr) begin
      pcnt_r <= '0;
    end else if (cmd.pcnt_inc) begin
      pcnt_r <= pcnt_r + CW'(1);
    end
    if (cmd.shr_ld) begin
      shr_r  <= val_r;
      slot_r <= '0;
    end else if (cmd.shr_shift) begin
      shr_r  <= shr_r >> width_r;
      slot_r <= slot_r + 6'd1;
    end
    if (cmd.idx_zero) begin
      idx_r <= '0;
    end else if (cmd.idx_ld_ram) begin
      idx_r <= stat.stale ? '0 : idx_rdata[PAW-1:0];
    end else if (cmd.idx_ld_pcnt) begin
      idx_r <= pcnt_r[PAW-1:0];
    end else if (cmd.idx_ld_count) begin
      idx_r <= count_r[PAW-1:0];
    end
    vld_q_r  <= pal_vld_r[pal_raddr];
    zero_q_r <= (pal_raddr == '0);
    if (cmd.fin) begin
      out_r.id_out    <= cmd.fin_get ? pal_eff : 32'd0;
      out_r.status    <= cmd.fin_status;
      out_r.load_done <= cmd.fin_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CW'(1);
      uniform_r <= 1'b1;
      width_r   <= '0;
      ent_r     <= '0;
      pal_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cmd.fin;
      if (cmd.cnt_one) begin
        count_r <= CW'(1);
      end else if (cmd.cnt_ld) begin
        count_r <= val_r[CW-1:0];
      end else if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.uni_set) begin
        uniform_r <= 1'b1;
      end else if (cmd.uni_clr) begin
        uniform_r <= 1'b0;
      end
      if (cmd.width_ld) begin
        width_r <= hdr_b[4:0];
      end
      if (cmd.ent_clr) begin
        ent_r <= '0;
      end else if (cmd.ent_inc) begin
        ent_r <= stat.ent_last ? '0 : ent_r + EAW'(1);
      end
      if (pal_we) begin
        pal_vld_r[pal_waddr] <= 1'b1;
      end
    end
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(PALETTE_DEPTH)))
    else $error("palette count left its legal range");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.full)
    else $error("palette append past its depth");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |=> !out_vld_r)
    else $error("result strobe held for two cycles");

endmodule

@@ hw/rtl/pisd_ctrl.sv @@
// Controller: sequences each item over the datapath and tracks the load phase.
// Depends on pisd_pkg.
module pisd_ctrl
  import pisd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  pisd_stat_t stat,
  output pisd_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WRAP   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_GETI   = 4'd3;
  localparam logic [3:0] S_GETP   = 4'd4;
  localparam logic [3:0] S_GETO   = 4'd5;
  localparam logic [3:0] S_SRCH   = 4'd6;
  localparam logic [3:0] S_SCMP   = 4'd7;
  localparam logic [3:0] S_APPEND = 4'd8;
  localparam logic [3:0] S_SWR    = 4'd9;
  localparam logic [3:0] S_IWR    = 4'd10;
  localparam logic [3:0] S_CLR    = 4'd11;
  localparam logic [3:0] S_UNPACK = 4'd12;
  localparam logic [3:0] S_FIXR   = 4'd13;
  localparam logic [3:0] S_FIXW   = 4'd14;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SINGLE = 3'd1;
  localparam logic [2:0] PH_WORDS  = 3'd2;
  localparam logic [2:0] PH_SIZE   = 3'd3;
  localparam logic [2:0] PH_IDS    = 3'd4;

  logic [3:0] state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic       ret_r, ret_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ph_nxt    = ph_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_WRAP;
        end
      end
      S_WRAP: begin
        if (stat.pos_ge) begin
          cmd.pos_sub = 1'b1;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.opcode)
          OP_HDR: begin
            cmd.ent_clr = 1'b1;
            if (stat.hdr_zero) begin
              ph_nxt    = PH_SINGLE;
              cmd.fin   = 1'b1;
              state_nxt = S_IDLE;
            end else if (stat.hdr_big) begin
              ph_nxt         = PH_IDLE;
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_WIDTH;
              state_nxt      = S_IDLE;
            end else begin
              cmd.width_ld = 1'b1;
              cmd.uni_clr  = 1'b1;
              ph_nxt       = PH_WORDS;
              ret_nxt      = 1'b0;
              state_nxt    = S_CLR;
            end
          end
          OP_VAL: begin
            case (ph_r)
              PH_SINGLE: begin
                cmd.pal_we   = 1'b1;
                cmd.pal_wsel = PW_ZERO;
                cmd.cnt_one  = 1'b1;
                cmd.uni_set  = 1'b1;
                ph_nxt       = PH_IDLE;
                cmd.fin      = 1'b1;
                cmd.fin_done = 1'b1;
                state_nxt    = S_IDLE;
              end
              PH_WORDS: begin
                cmd.shr_ld = 1'b1;
                state_nxt  = S_UNPACK;
              end
              PH_SIZE: begin
                if (stat.size_bad) begin
                  ph_nxt         = PH_IDLE;
                  cmd.fin_status = ST_SIZE;
                end else begin
                  cmd.cnt_ld   = 1'b1;
                  cmd.pcnt_clr = 1'b1;
                  ph_nxt       = PH_IDS;
                end
                cmd.fin   = 1'b1;
                state_nxt = S_IDLE;
              end
              PH_IDS: begin
                cmd.pal_we   = 1'b1;
                cmd.pal_wsel = PW_PCNT;
                cmd.pcnt_inc = 1'b1;
                if (stat.ids_last) begin
                  // drop indices the new palette no longer covers
                  cmd.ent_clr = 1'b1;
                  ph_nxt      = PH_IDLE;
                  state_nxt   = S_FIXR;
                end else begin
                  cmd.fin   = 1'b1;
                  state_nxt = S_IDLE;
                end
              end
              default: begin
                cmd.fin        = 1'b1;
                cmd.fin_status = ST_SEQ;
                state_nxt      = S_IDLE;
              end
            endcase
          end
          default: begin
            if (ph_r != PH_IDLE) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_SEQ;
              state_nxt      = S_IDLE;
            end else if (stat.opcode == OP_GET) begin
              if (stat.uniform) begin
                cmd.idx_zero = 1'b1;
                state_nxt    = S_GETP;
              end else begin
                state_nxt = S_GETI;
              end
            end else begin
              cmd.pcnt_clr = 1'b1;
              state_nxt    = S_SRCH;
            end
          end
        endcase
      end
      S_GETI: begin
        cmd.idx_ld_ram = 1'b1;
        state_nxt      = S_GETP;
      end
      S_GETP: begin
        cmd.pal_rsel = 1'b1;
        state_nxt    = S_GETO;
      end
      S_GETO: begin
        cmd.fin     = 1'b1;
        cmd.fin_get = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        state_nxt = stat.srch_end ? S_APPEND : S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          cmd.idx_ld_pcnt = 1'b1;
          state_nxt       = S_SWR;
        end else begin
          cmd.pcnt_inc = 1'b1;
          state_nxt    = S_SRCH;
        end
      end
      S_APPEND: begin
        if (stat.full) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_FULL;
          state_nxt      = S_IDLE;
        end else begin
          cmd.pal_we       = 1'b1;
          cmd.pal_wsel     = PW_COUNT;
          cmd.idx_ld_count = 1'b1;
          cmd.cnt_inc      = 1'b1;
          state_nxt        = S_SWR;
        end
      end
      S_SWR: begin
        if (stat.uniform && stat.idx_is_zero) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.uniform) begin
          cmd.uni_clr = 1'b1;
          cmd.ent_clr = 1'b1;
          ret_nxt     = 1'b1;
          state_nxt   = S_CLR;
        end else begin
          state_nxt = S_IWR;
        end
      end
      S_IWR: begin
        cmd.idx_we   = 1'b1;
        cmd.idx_wsel = IW_IDX;
        cmd.fin      = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_CLR: begin
        cmd.idx_we   = 1'b1;
        cmd.idx_wsel = IW_ZERO;
        cmd.ent_inc  = 1'b1;
        if (stat.ent_last) begin
          if (ret_r) begin
            state_nxt = S_IWR;
          end else begin
            cmd.fin   = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_UNPACK: begin
        cmd.idx_we    = 1'b1;
        cmd.idx_wsel  = IW_SLOT;
        cmd.ent_inc   = 1'b1;
        cmd.shr_shift = 1'b1;
        if (stat.ent_last) begin
          ph_nxt    = PH_SIZE;
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.slot_last) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FIXR: begin
        cmd.idx_rsel = 1'b1;
        state_nxt    = S_FIXW;
      end
      S_FIXW: begin
        cmd.idx_we   = stat.stale;
        cmd.idx_wsel = IW_ZERO;
        cmd.ent_inc  = 1'b1;
        if (stat.ent_last) begin
          cmd.fin      = 1'b1;
          cmd.fin_done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_FIXR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_IDLE;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      ret_r   <= ret_nxt;
    end
  end

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (state_r == S_IDLE))
    else $error("item finished but controller did not return to idle");

  a_get_not_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_get |-> (ph_r == PH_IDLE))
    else $error("get answered while a stream load is open");

  a_one_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pal_we && cmd.idx_we))
    else $error("palette and index store written in the same cycle");

endmodule

@@ hw/rtl/paletted_index_store_decoder_unit.sv @@
// Top level of the paletted index store decoder: controller plus datapath.
// Depends on pisd_pkg, pisd_ctrl, pisd_dp (and pisd_ram through pisd_dp).
//
// Usage
//   Input: drive in_item and raise start; the beat is taken on a rising edge
//   with start high and busy low. busy stays high until the item is done.
//   Output: every item gives exactly one result beat, shown on out_item for
//   one cycle with out_strobe high. The receiver cannot stall; sample it then.
//   A position of ENTRY_COUNT or more is folded back into range by repeated
//   subtraction of ENTRY_COUNT. A set searches the palette from index 0 and
//   appends the id if it is not found and there is room; index 0 leaves a
//   uniform store alone, and a set that turns a uniform store non-uniform
//   first runs a clearing sweep over the store. A packed load header also
//   clears the store. The last palette id starts a stale index cleanup that
//   walks the whole store, read then write.
//   Next item can start on the cycle the strobe is shown.
//   Reset: palette holds one entry (id 1), store reads uniform zero, no load
//   is open. No clearing pass: the uniform flag masks the store until cleared.
module paletted_index_store_decoder_unit
  import pisd_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT   = 4096,
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pisd_in_t  in_item,
  output logic      out_strobe,
  output pisd_out_t out_item
);

  pisd_cmd_t  cmd;
  pisd_stat_t stat;

  // sequence each item
  pisd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .cmd(cmd)
  );

  // hold state, RAMs and the result register
  pisd_dp #(
    .ENTRY_COUNT(ENTRY_COUNT), .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
    .out_strobe(out_strobe), .out_item(out_item)
  );

endmodule

@@ tb/sv/paletted_index_store_decoder_unit_test.sv @@
// Self-checking testbench for paletted_index_store_decoder_unit: stream loads, gets and sets.
// Depends on pisd_pkg and the RTL of the unit; a built-in predictor gives expected beats.
module paletted_index_store_decoder_unit_test
  import pisd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRY_COUNT   = 4096;
  localparam int unsigned PALETTE_DEPTH = 256;
  localparam int unsigned ITEM_TARGET   = 1550;

  typedef enum int unsigned {LD_IDLE, LD_SINGLE, LD_WORDS, LD_SIZE, LD_IDS} load_phase_t;

  // one pending command beat plus the sender idle percentage of its phase
  typedef struct {
    pisd_in_t    cmd;
    int unsigned idle_pct;
  } pending_beat_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  pisd_in_t  in_item;
  logic      out_strobe;
  pisd_out_t out_item;

  paletted_index_store_decoder_unit #(
    .ENTRY_COUNT  (ENTRY_COUNT),
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the store, the palette and the loader.
  // ---------------------------------------------------------------------------
  logic [15:0]  index_mem [ENTRY_COUNT];
  logic [31:0]  palette_mem [PALETTE_DEPTH];
  int unsigned  palette_size;
  bit           store_uniform;
  load_phase_t  phase;
  int unsigned  entry_w;
  int unsigned  load_count;

  pending_beat_t pending_beats[$];
  pisd_out_t     expected_beats[$];
  int unsigned   mismatch_count;
  int unsigned   beats_queued;
  int unsigned   cur_idle_pct;
  bit            beat_taken;

  function automatic void clear_store();
    for (int unsigned i = 0; i < ENTRY_COUNT; i++) index_mem[i] = '0;
  endfunction

  // Compute the result beat of one command and advance the private state.
  function automatic pisd_out_t decode_beat(pisd_in_t c);
    pisd_out_t   r;
    int unsigned b;
    int unsigned per;
    int unsigned idx;
    int unsigned p;
    bit          found;
    logic [31:0] v;
    logic [31:0] mask;
    r = '0;
    v = c.stream_value;
    p = c.position % ENTRY_COUNT;
    if (c.opcode == OP_HDR) begin
      b = v[7:1];
      load_count = 0;
      if (b == 0) begin
        entry_w = 0;
        phase = LD_SINGLE;
      end else if (b > 16) begin
        phase = LD_IDLE;
        r.status = ST_WIDTH;
      end else begin
        entry_w = b;
        clear_store();
        store_uniform = 0;
        phase = LD_WORDS;
      end
    end else if (c.opcode == OP_VAL) begin
      case (phase)
        LD_SINGLE: begin
          palette_mem[0] = v;
          palette_size = 1;
          store_uniform = 1;
          phase = LD_IDLE;
          r.load_done = 1'b1;
        end
        LD_WORDS: begin
          b = (entry_w < 1 || entry_w > 16) ? 1 : entry_w;
          per = 32 / b;
          mask = (32'd1 << b) - 32'd1;
          // low slot first; drop slots past the last entry
          for (int unsigned s = 0; s < per && load_count < ENTRY_COUNT; s++) begin
            index_mem[load_count] = 16'((v >> (s * b)) & mask);
            load_count++;
          end
          if (load_count >= ENTRY_COUNT) begin
            load_count = 0;
            phase = LD_SIZE;
          end
        end
        LD_SIZE: begin
          if (v == 0 || v > PALETTE_DEPTH) begin
            r.status = ST_SIZE;
            phase = LD_IDLE;
          end else begin
            palette_size = v;
            load_count = 0;
            phase = LD_IDS;
          end
        end
        LD_IDS: begin
          if (load_count < PALETTE_DEPTH) palette_mem[load_count] = v;
          load_count++;
          if (load_count >= palette_size) begin
            // zero every index that the new palette no longer covers
            for (int unsigned i = 0; i < ENTRY_COUNT; i++)
              if (index_mem[i] >= palette_size) index_mem[i] = '0;
            load_count = 0;
            phase = LD_IDLE;
            r.load_done = 1'b1;
          end
        end
        default: r.status = ST_SEQ;
      endcase
    end else if (phase != LD_IDLE) begin
      r.status = ST_SEQ;
    end else if (c.opcode == OP_GET) begin
      idx = store_uniform ? 0 : index_mem[p];
      if (idx >= palette_size || idx >= PALETTE_DEPTH) idx = 0;
      r.id_out = palette_mem[idx];
    end else begin
      idx = palette_size;
      found = 0;
      for (int unsigned i = 0; i < palette_size && i < PALETTE_DEPTH; i++) begin
        if (!found && palette_mem[i] == c.new_id) begin
          idx = i;
          found = 1;
        end
      end
      if (!found) begin
        if (palette_size >= PALETTE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          idx = palette_size;
          palette_mem[idx] = c.new_id;
          palette_size++;
        end
      end
      if (r.status == ST_OK && !(store_uniform && idx == 0)) begin
        if (store_uniform) begin
          clear_store();
          store_uniform = 0;
        end
        index_mem[p] = 16'(idx);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic [1:0] op, logic [31:0] val, logic [11:0] pos,
                           logic [31:0] nid);
    pending_beat_t pb;
    pb.cmd.opcode       = op;
    pb.cmd.stream_value = val;
    pb.cmd.position     = pos;
    pb.cmd.new_id       = nid;
    pb.idle_pct         = cur_idle_pct;
    pending_beats.insert(pending_beats.size(), pb);
    beats_queued++;
  endtask

  // ids drawn mostly from a small pool so sets hit existing palette entries
  function automatic logic [31:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 32'($urandom_range(15));
    if (r < 70) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] header_word(int unsigned b);
    logic [31:0] w;
    w = $urandom;
    w[7:1] = b[6:0];
    return w;
  endfunction

  task automatic push_access();
    if ($urandom_range(1))
      push_beat(OP_GET, $urandom, 12'($urandom), $urandom);
    else
      push_beat(OP_SET, $urandom, 12'($urandom), pick_id());
  endtask

  // Queue a packed load; word_limit below the full count cuts the stream short.
  task automatic push_load(int unsigned b, int unsigned size, int unsigned word_limit,
                           bit distinct_ids);
    int unsigned per;
    int unsigned nwords;
    per = 32 / b;
    nwords = (ENTRY_COUNT + per - 1) / per;
    push_beat(OP_HDR, header_word(b), 12'($urandom), $urandom);
    for (int unsigned i = 0; i < nwords && i < word_limit; i++) begin
      // mask half the words so most indices stay inside a small palette
      push_beat(OP_VAL, $urandom_range(1) ? $urandom : ($urandom & 32'h1111_1111),
                12'($urandom), $urandom);
    end
    if (word_limit < nwords) return;
    push_beat(OP_VAL, size, 12'($urandom), $urandom);
    if (size == 0 || size > PALETTE_DEPTH) return;
    for (int unsigned i = 0; i < size; i++)
      push_beat(OP_VAL, distinct_ids ? $urandom : pick_id(), 12'($urandom), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge, one assignment per signal.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pending_beat_t nb;
    if (rst_n && (!start || beat_taken)) begin
      if (pending_beats.size() != 0 &&
          $urandom_range(99) >= pending_beats[0].idle_pct) begin
        nb      = pending_beats.pop_front();
        in_item <= nb.cmd;
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Predict on every accepted command beat.
  always @(posedge clk) begin
    beat_taken <= rst_n && start && !busy;
    if (rst_n && start && !busy)
      expected_beats.insert(expected_beats.size(), decode_beat(in_item));
  end

  // Monitor: compare each strobed result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: id_out=%h status=%0d load_done=%0b",
                   out_item.id_out, out_item.status, out_item.load_done);
      end else begin
        pisd_out_t exp_beat;
        exp_beat = expected_beats.pop_front();
        if (out_item.id_out !== exp_beat.id_out || out_item.status !== exp_beat.status ||
            out_item.load_done !== exp_beat.load_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected id_out=%h status=%0d load_done=%0b, ",
                     exp_beat.id_out, exp_beat.status, exp_beat.load_done,
                     "got id_out=%h status=%0d load_done=%0b",
                     out_item.id_out, out_item.status, out_item.load_done);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int unsigned phase_sel;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    beat_taken     = 1'b0;
    mismatch_count = 0;
    beats_queued   = 0;
    cur_idle_pct   = 0;
    clear_store();
    for (int unsigned i = 0; i < PALETTE_DEPTH; i++) palette_mem[i] = '0;
    palette_mem[0] = 32'd1;
    palette_size   = 1;
    store_uniform  = 1;
    phase          = LD_IDLE;
    entry_w        = 0;
    load_count     = 0;

    // Directed: reset contents, uniform store, sequence errors, width limits.
    push_beat(OP_GET, 32'h0, 12'd0, 32'h0);
    push_beat(OP_SET, 32'h0, 12'd0, 32'd1);              // index 0 keeps it uniform
    push_beat(OP_GET, 32'hFFFF_FFFF, 12'd4095, 32'h0);
    push_beat(OP_SET, 32'h0, 12'd4095, 32'hFFFF_FFFF);   // first nonzero index clears
    push_beat(OP_GET, 32'h0, 12'd4095, 32'h0);
    push_beat(OP_GET, 32'h0, 12'd0, 32'hFFFF_FFFF);
    push_beat(OP_SET, 32'h0, 12'd0, 32'h0);
    push_beat(OP_VAL, 32'hFFFF_FFFF, 12'd0, 32'h0);      // value with no load open
    push_beat(OP_HDR, header_word(17), 12'd0, 32'h0);    // width just over the limit
    push_beat(OP_HDR, 32'hFFFF_FFFF, 12'd0, 32'h0);      // widest header byte
    push_beat(OP_HDR, 32'hFFFF_FF00, 12'd0, 32'h0);      // single id load
    push_beat(OP_GET, 32'h0, 12'd5, 32'h0);              // access mid load
    push_beat(OP_SET, 32'h0, 12'd5, 32'h7);
    push_beat(OP_VAL, 32'hFFFF_FFFF, 12'd0, 32'h0);
    push_beat(OP_GET, 32'h0, 12'd4095, 32'h0);
    push_beat(OP_HDR, header_word(1), 12'd0, 32'h0);     // packed load, then abandon it
    push_beat(OP_VAL, 32'hFFFF_FFFF, 12'd0, 32'h0);
    push_beat(OP_HDR, 32'h0000_0001, 12'd0, 32'h0);      // header restarts as single id
    push_beat(OP_VAL, 32'h0, 12'd0, 32'h0);
    push_beat(OP_SET, 32'h0, 12'd100, 32'h0);
    push_beat(OP_GET, 32'h0, 12'd100, 32'h0);

    // Loads with the size and palette extremes.
    push_load(1, 0, ENTRY_COUNT, 0);                     // zero palette size
    push_access();
    push_load(2, PALETTE_DEPTH + 1, ENTRY_COUNT, 0);     // size over the depth
    push_access();
    push_load(1, 1, ENTRY_COUNT, 0);                     // every nonzero index goes stale
    push_beat(OP_GET, 32'h0, 12'd1, 32'h0);
    push_load(16, 2, 24, 0);                             // widest entries, cut short
    push_beat(OP_HDR, header_word(1), 12'd0, 32'h0);
    push_load(1, PALETTE_DEPTH, ENTRY_COUNT, 1);         // full palette
    for (int i = 0; i < 6; i++) push_beat(OP_SET, 32'h0, 12'($urandom), $urandom);
    push_beat(OP_SET, 32'h0, 12'd7, palette_mem[0]);
    push_load(3, 4, ENTRY_COUNT, 0);

    // Random part; idle phases rotate every couple of hundred beats.
    phase_sel = 0;
    while (beats_queued < ITEM_TARGET) begin
      if (beats_queued / 200 != phase_sel) begin
        phase_sel = beats_queued / 200;
        case (phase_sel % 4)
          0: cur_idle_pct = 0;
          1: cur_idle_pct = 80;
          2: cur_idle_pct = 0;
          default: cur_idle_pct = 16;
        endcase
      end
      r = $urandom_range(99);
      if (r < 76) begin
        push_access();
      end else if (r < 79) begin
        push_beat(OP_VAL, $urandom, 12'($urandom), $urandom);
      end else if (r < 83) begin
        push_beat(OP_HDR, header_word(0), 12'($urandom), $urandom);
        if ($urandom_range(3) != 0) push_beat(OP_VAL, pick_id(), 12'($urandom), $urandom);
        else push_access();
      end else if (r < 86) begin
        push_beat(OP_HDR, header_word($urandom_range(127, 17)), 12'($urandom), $urandom);
      end else if (r < 89) begin
        // broken load: cut inside the words, then noise
        push_load($urandom_range(16, 1), 1, $urandom_range(6), 0);
        if ($urandom_range(1)) push_access();
        else push_beat(OP_HDR, header_word($urandom_range(127, 17)), 12'd0, 32'h0);
      end else if (r < 91) begin
        r = $urandom_range(9);
        push_load(r < 7 ? $urandom_range(2, 1) : $urandom_range(4, 3),
                  $urandom_range(3) == 0 ? $urandom_range(PALETTE_DEPTH, 1)
                                         : $urandom_range(8, 1),
                  ENTRY_COUNT, 0);
      end else begin
        push_access();
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || start || expected_beats.size() != 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0)
      $display("paletted_index_store_decoder_unit_test OK");
    else
      $display("paletted_index_store_decoder_unit_test NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("paletted_index_store_decoder_unit_test NOT OK");
    $finish;
  end

endmodule
